// ===== rtl/core/cvg_pkg.sv =====
// package with types, constants and the quarter-wave sine table of the cylinder vertex generator
`timescale 1ns / 1ps
`default_nettype none

package cvg_pkg;

    // block limits
    localparam int SUBDIV_MAX = 256;
    localparam int PHASE_BITS = 12;
    localparam int SEG_W      = 8;
    localparam int SUB_W      = 9;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 3;

    // configuration port
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SUBDIV = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CAPPED = 3'd5;

    localparam logic [PDATA_W-1:0] ROW0_RST   = 64'h0000_0000_0000_0100;
    localparam logic [PDATA_W-1:0] ROW1_RST   = 64'h0000_0000_0100_0000;
    localparam logic [PDATA_W-1:0] ROW2_RST   = 64'h0000_0100_0000_0000;
    localparam logic [PDATA_W-1:0] ROW3_RST   = 64'h0100_0000_0000_0000;
    localparam logic [SUB_W-1:0]   SUBDIV_RST = 9'd16;

    // part codes
    localparam logic [CMD_W-1:0] CMD_SIDE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOTTOM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TOP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    localparam logic [IDX_W-1:0] SIDE_LAST_IDX = 3'd5;
    localparam logic [IDX_W-1:0] CAP_LAST_IDX  = 3'd2;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // ring phase divider
    localparam int NUM_W      = SUB_W + PHASE_BITS;
    localparam int PDIV_STEPS = PHASE_BITS + 1;

    // sine table
    localparam int QUARTER   = 1 << (PHASE_BITS - 2);
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam int ROM_AW    = PHASE_BITS - 1;
    localparam int TRIG_W    = 15;
    localparam int SC_W      = 17;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam int ONE_Q14   = 16384;

    // transform and coordinate divide
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 33;
    localparam int SUM_W     = 33;
    localparam int MAG_W     = 32;
    localparam int FRAC_SH   = 16;
    localparam int ONE_SH    = 14;
    localparam int DIV_STEPS = 32;
    localparam int LANES     = 3;

    localparam logic [MAG_W-1:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [MAG_W-1:0] POS_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEG_W-1:0] segment;
    } t_in_item;

    typedef struct packed {
        logic signed [MAG_W-1:0] pos_x;
        logic signed [MAG_W-1:0] pos_y;
        logic signed [MAG_W-1:0] pos_z;
        logic                    w_zero;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [3:0][PDATA_W-1:0] rows;
        logic [SUB_W-1:0]        s_eff;
        logic                    capped;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEG_W-1:0] seg;
    } t_job;

    typedef struct packed {
        logic xbit;
        logic ring1;
        logic center;
        logic last;
    } t_vtx;

    typedef struct packed {
        logic vld;
        logic xbit;
        logic center;
        logic last;
    } t_side;

    typedef struct packed {
        logic [3:0][SUM_W-1:0] row;
    } t_sums;

    typedef logic [TRIG_W-1:0] t_sin_rom [ROM_DEPTH];

    // vertex order of each part
    function automatic t_vtx vtx_info(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        t_vtx v;
        v = '0;
        if (cmd == CMD_SIDE) begin
            case (idx)
                3'd0: v = '{xbit: 1'b0, ring1: 1'b0, center: 1'b0, last: 1'b0};
                3'd1: v = '{xbit: 1'b0, ring1: 1'b1, center: 1'b0, last: 1'b0};
                3'd2: v = '{xbit: 1'b1, ring1: 1'b0, center: 1'b0, last: 1'b0};
                3'd3: v = '{xbit: 1'b0, ring1: 1'b1, center: 1'b0, last: 1'b0};
                3'd4: v = '{xbit: 1'b1, ring1: 1'b1, center: 1'b0, last: 1'b0};
                default: v = '{xbit: 1'b1, ring1: 1'b0, center: 1'b0, last: 1'b1};
            endcase
        end else begin
            v.xbit = (cmd == CMD_TOP);
            case (idx)
                3'd0: begin
                    v.center = 1'b1;
                end
                3'd1: begin
                    v.ring1 = (cmd == CMD_TOP);
                end
                default: begin
                    v.ring1 = (cmd != CMD_TOP);
                    v.last  = 1'b1;
                end
            endcase
        end
        return v;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) / Q30_ONE;
    endfunction

    // odd polynomial of sin over a quarter turn, Q14
    function automatic logic [TRIG_W-1:0] quarter_sine(input int u);
        longint t;
        longint t2;
        longint acc;
        t   = longint'(u) <<< (30 - (PHASE_BITS - 2));
        t2  = mul_q30(t, t);
        acc = 64'sd172272;
        acc = -64'sd5026995 + mul_q30(t2, acc);
        acc = 64'sd85569306 + mul_q30(t2, acc);
        acc = -64'sd693598670 + mul_q30(t2, acc);
        acc = 64'sd1686629713 + mul_q30(t2, acc);
        acc = mul_q30(t, acc);
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 64'sd32768) / 64'sd65536;
        if (acc > ONE_Q14) begin
            acc = ONE_Q14;
        end
        return TRIG_W'(acc);
    endfunction

    function automatic t_sin_rom sin_rom_init();
        t_sin_rom r;
        for (int u = 0; u < ROM_DEPTH; u++) begin
            r[u] = quarter_sine(u);
        end
        return r;
    endfunction

    // table address of a phase after folding into the first quarter
    function automatic logic [ROM_AW-1:0] rom_addr(input logic [PHASE_BITS-1:0] p);
        logic [ROM_AW-1:0] r;
        r = ROM_AW'(p[PHASE_BITS-3:0]);
        return p[PHASE_BITS-2] ? (ROM_AW'(QUARTER) - r) : r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cvg_front.sv =====
// front end: takes input items, drops those that emit nothing, hands the rest to the queue
`timescale 1ns / 1ps
`default_nettype none

module cvg_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cvg_pkg::t_in_item i_in_data,
    input  cvg_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output cvg_pkg::t_job     o_job
);
    import cvg_pkg::*;

    logic r_valid;
    logic r_emit;
    t_job r_job;
    logic n_emit;
    logic accept;

    // item classification
    always_comb begin
        n_emit = (i_cfg.s_eff != '0) && (SUB_W'(i_in_data.segment) < i_cfg.s_eff) &&
                 (i_in_data.cmd != CMD_NONE) &&
                 ((i_in_data.cmd == CMD_SIDE) || i_cfg.capped);
    end

    assign o_in_stall = r_valid && r_emit && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && r_emit && !i_q_full;
    assign o_job      = r_job;

    // holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_emit  <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= accept;
            r_emit  <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= '{cmd: i_in_data.cmd, seg: i_in_data.segment};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvg_queue.sv =====
// short item queue between the front end and the vertex back end
`timescale 1ns / 1ps
`default_nettype none

module cvg_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  cvg_pkg::t_job          i_data,
    input  logic                   i_pop,
    output cvg_pkg::t_job          o_head,
    output logic                   o_full,
    output logic                   o_empty,
    output logic [cvg_pkg::QCNT_W-1:0] o_count
);
    import cvg_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvg_back.sv =====
// back end: steps through the vertices of each item, finds ring phase, sine and cosine, matrix rows
`timescale 1ns / 1ps
`default_nettype none

module cvg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  cvg_pkg::t_cfg i_cfg,
    input  logic          i_q_empty,
    input  cvg_pkg::t_job i_q_head,
    output logic          o_pop,
    output logic          o_vld,
    output logic          o_last,
    output cvg_pkg::t_sums o_sums
);
    import cvg_pkg::*;

    localparam t_sin_rom SIN_ROM = sin_rom_init();

    // vertex sequencer
    logic             r_busy;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] last_idx;
    logic             fin;
    logic             take;
    t_vtx             vtx;
    logic [SUB_W-1:0] ring_k;
    logic [NUM_W-1:0] ring_num;

    assign last_idx = (r_job.cmd == CMD_SIDE) ? SIDE_LAST_IDX : CAP_LAST_IDX;
    assign fin      = r_busy && (r_idx == last_idx);
    assign take     = i_en && (!r_busy || fin);
    assign o_pop    = take && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= !i_q_empty;
            r_idx  <= '0;
        end else if (i_en) begin
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_head;
        end
    end

    always_comb begin
        vtx      = vtx_info(r_job.cmd, r_idx);
        ring_k   = SUB_W'(r_job.seg) + SUB_W'(vtx.ring1);
        ring_num = {ring_k, PHASE_BITS'(0)} + NUM_W'(i_cfg.s_eff >> 1);
    end

    // ring phase divider, one quotient bit a stage
    t_side                  r_ps    [0:PDIV_STEPS];
    logic [SUB_W-1:0]       r_prem  [0:PDIV_STEPS];
    logic [PDIV_STEPS-1:0]  r_pbits [0:PDIV_STEPS];
    logic [PDIV_STEPS-1:0]  r_pq    [0:PDIV_STEPS];
    logic [SUB_W-1:0]       n_trial [1:PDIV_STEPS];
    logic [SUB_W-1:0]       n_prem  [1:PDIV_STEPS];
    logic                   n_qbit  [1:PDIV_STEPS];

    always_comb begin
        for (int i = 1; i <= PDIV_STEPS; i++) begin
            n_trial[i] = {r_prem[i-1][SUB_W-2:0], r_pbits[i-1][PDIV_STEPS-1]};
            n_qbit[i]  = (n_trial[i] >= i_cfg.s_eff);
            n_prem[i]  = n_qbit[i] ? (n_trial[i] - i_cfg.s_eff) : n_trial[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= PDIV_STEPS; i++) begin
                r_ps[i] <= '0;
            end
        end else if (i_en) begin
            r_ps[0] <= '{vld: r_busy, xbit: vtx.xbit, center: vtx.center, last: vtx.last};
            for (int i = 1; i <= PDIV_STEPS; i++) begin
                r_ps[i] <= r_ps[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prem[0]  <= SUB_W'(ring_num[NUM_W-1:PDIV_STEPS]);
            r_pbits[0] <= ring_num[PDIV_STEPS-1:0];
            r_pq[0]    <= '0;
            for (int i = 1; i <= PDIV_STEPS; i++) begin
                r_prem[i]  <= n_prem[i];
                r_pbits[i] <= {r_pbits[i-1][PDIV_STEPS-2:0], 1'b0};
                r_pq[i]    <= {r_pq[i-1][PDIV_STEPS-2:0], n_qbit[i]};
            end
        end
    end

    // sine table reads for sine and cosine of the ring phase
    logic [PHASE_BITS-1:0] phase_s;
    logic [PHASE_BITS-1:0] phase_c;
    t_side                 r_as;
    logic [TRIG_W-1:0]     r_sin_mag;
    logic [TRIG_W-1:0]     r_cos_mag;
    logic                  r_sin_neg;
    logic                  r_cos_neg;

    assign phase_s = r_pq[PDIV_STEPS][PHASE_BITS-1:0];
    assign phase_c = phase_s + PHASE_BITS'(QUARTER);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin_mag <= SIN_ROM[rom_addr(phase_s)];
            r_cos_mag <= SIN_ROM[rom_addr(phase_c)];
            r_sin_neg <= phase_s[PHASE_BITS-1];
            r_cos_neg <= phase_c[PHASE_BITS-1];
        end
    end

    // signed point coordinates
    t_side                  r_bs;
    logic signed [SC_W-1:0] r_y;
    logic signed [SC_W-1:0] r_z;
    logic signed [SC_W-1:0] n_y;
    logic signed [SC_W-1:0] n_z;

    always_comb begin
        n_y = r_cos_neg ? -$signed(SC_W'(r_cos_mag)) : $signed(SC_W'(r_cos_mag));
        n_z = r_sin_neg ? -$signed(SC_W'(r_sin_mag)) : $signed(SC_W'(r_sin_mag));
        if (r_as.center) begin
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // coefficient products for y and z
    logic signed [COEF_W-1:0] coef [4][4];
    t_side                    r_cs;
    logic signed [PROD_W-1:0] r_py [4];
    logic signed [PROD_W-1:0] r_pz [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = $signed(i_cfg.rows[r][COEF_W*c +: COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_py[r] <= PROD_W'(coef[r][1]) * PROD_W'(r_y);
                r_pz[r] <= PROD_W'(coef[r][2]) * PROD_W'(r_z);
            end
        end
    end

    // row sums with the x and w terms
    t_side                   r_ds;
    logic signed [SUM_W-1:0] r_sum [4];
    logic signed [SUM_W-1:0] n_base [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_base[r] = (SUM_W'(r_cs.xbit ? coef[r][0] : COEF_W'(0)) + SUM_W'(coef[r][3]))
                        <<< ONE_SH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_sum[r] <= r_py[r] + r_pz[r] + n_base[r];
            end
        end
    end

    // side-band valid through the tail stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as <= '0;
            r_bs <= '0;
            r_cs <= '0;
            r_ds <= '0;
        end else if (i_en) begin
            r_as <= r_ps[PDIV_STEPS];
            r_bs <= r_as;
            r_cs <= r_bs;
            r_ds <= r_cs;
        end
    end

    assign o_vld  = r_ds.vld;
    assign o_last = r_ds.last;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            o_sums.row[r] = r_sum[r];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cvg_div.sv =====
// perspective divide: three pipelined restoring dividers, saturation and the output register
`timescale 1ns / 1ps
`default_nettype none

module cvg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic               i_last,
    input  cvg_pkg::t_sums     i_sums,
    input  logic               i_out_stall,
    output logic               o_en,
    output logic               o_out_valid,
    output cvg_pkg::t_out_item o_out_data
);
    import cvg_pkg::*;

    typedef struct packed {
        logic ovf;
        logic neg;
        logic npos;
        logic nneg;
    } t_lane_fl;

    logic en;
    logic r_out_valid;
    t_out_item r_out;

    assign en          = !r_out_valid || !i_out_stall;
    assign o_en        = en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // magnitudes, signs and overflow check
    logic [SUM_W-1:0] abs_n [LANES];
    logic [SUM_W-1:0] abs_d;
    logic [MAG_W-1:0] mag_n [LANES];
    logic [MAG_W-1:0] mag_d;
    t_lane_fl         n_fl  [LANES];
    logic             den_neg;

    always_comb begin
        den_neg = i_sums.row[3][SUM_W-1];
        abs_d   = den_neg ? (~i_sums.row[3] + 1'b1) : i_sums.row[3];
        mag_d   = abs_d[MAG_W-1:0];
        for (int l = 0; l < LANES; l++) begin
            abs_n[l]     = i_sums.row[l][SUM_W-1] ? (~i_sums.row[l] + 1'b1) : i_sums.row[l];
            mag_n[l]     = abs_n[l][MAG_W-1:0];
            n_fl[l].ovf  = (MAG_W'(mag_n[l][MAG_W-1:FRAC_SH]) >= mag_d);
            n_fl[l].neg  = i_sums.row[l][SUM_W-1] ^ den_neg;
            n_fl[l].nneg = i_sums.row[l][SUM_W-1];
            n_fl[l].npos = !i_sums.row[l][SUM_W-1] && (i_sums.row[l] != '0);
        end
    end

    // divider stages, one quotient bit each; the dividend shifts out as quotient bits shift in
    logic             r_dv  [0:DIV_STEPS];
    logic             r_dl  [0:DIV_STEPS];
    logic             r_dz  [0:DIV_STEPS];
    logic [MAG_W-1:0] r_ad  [0:DIV_STEPS];
    t_lane_fl         r_fl  [0:DIV_STEPS][LANES];
    logic [MAG_W-1:0] r_rem [0:DIV_STEPS][LANES];
    logic [MAG_W-1:0] r_dq  [0:DIV_STEPS][LANES];
    logic [MAG_W:0]   n_trial [1:DIV_STEPS][LANES];
    logic             n_qbit  [1:DIV_STEPS][LANES];
    logic [MAG_W:0]   n_diff  [1:DIV_STEPS][LANES];

    always_comb begin
        for (int i = 1; i <= DIV_STEPS; i++) begin
            for (int l = 0; l < LANES; l++) begin
                n_trial[i][l] = {r_rem[i-1][l], r_dq[i-1][l][MAG_W-1]};
                n_qbit[i][l]  = (n_trial[i][l] >= {1'b0, r_ad[i-1]});
                n_diff[i][l]  = n_trial[i][l] - {1'b0, r_ad[i-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= i_vld;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0] <= i_last;
            r_dz[0] <= (mag_d == '0);
            r_ad[0] <= mag_d;
            for (int l = 0; l < LANES; l++) begin
                r_fl[0][l]  <= n_fl[l];
                r_rem[0][l] <= MAG_W'(mag_n[l][MAG_W-1:FRAC_SH]);
                r_dq[0][l]  <= {mag_n[l][FRAC_SH-1:0], FRAC_SH'(0)};
            end
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_dl[i] <= r_dl[i-1];
                r_dz[i] <= r_dz[i-1];
                r_ad[i] <= r_ad[i-1];
                for (int l = 0; l < LANES; l++) begin
                    r_fl[i][l]  <= r_fl[i-1][l];
                    r_rem[i][l] <= n_qbit[i][l] ? n_diff[i][l][MAG_W-1:0]
                                                : n_trial[i][l][MAG_W-1:0];
                    r_dq[i][l]  <= {r_dq[i-1][l][MAG_W-2:0], n_qbit[i][l]};
                end
            end
        end
    end

    // sign and saturation
    logic [MAG_W-1:0] n_res [LANES];
    logic [MAG_W-1:0] q;
    t_lane_fl         fl;

    always_comb begin
        q  = '0;
        fl = '0;
        for (int l = 0; l < LANES; l++) begin
            q  = r_dq[DIV_STEPS][l];
            fl = r_fl[DIV_STEPS][l];
            if (r_dz[DIV_STEPS]) begin
                n_res[l] = fl.npos ? POS_MAX : (fl.nneg ? POS_MIN : '0);
            end else if (fl.ovf) begin
                n_res[l] = fl.neg ? POS_MIN : POS_MAX;
            end else if (fl.neg) begin
                n_res[l] = (q > POS_MIN) ? POS_MIN : (~q + 1'b1);
            end else begin
                n_res[l] = q[MAG_W-1] ? POS_MAX : q;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pos_x  <= n_res[0];
            r_out.pos_y  <= n_res[1];
            r_out.pos_z  <= n_res[2];
            r_out.w_zero <= r_dz[DIV_STEPS];
            r_out.last   <= r_dl[DIV_STEPS];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cylinder_vertex_generator_top.sv =====
// top level: configuration registers, front end, queue, vertex back end and divide stage
// path of an item: front holding stage, queue, back end stages, divider stages, output register
// throughput: one vertex per cycle while the output is not stalled; a side item gives 6 vertices, a cap item 3
// the rate is set by the single transform and divide pipeline that every vertex passes
// items that emit nothing are dropped in the front end
// reset (synchronous, active low) empties the pipeline and restores the identity matrix
`timescale 1ns / 1ps
`default_nettype none

module cylinder_vertex_generator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cvg_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cvg_pkg::t_out_item              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cvg_pkg::PADDR_W-1:0]     paddr,
    input  logic [cvg_pkg::PDATA_W-1:0]     pwdata,
    output logic [cvg_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import cvg_pkg::*;

    // configuration registers
    logic [3:0][PDATA_W-1:0] r_rows;
    logic [SUB_W-1:0]        r_subdiv;
    logic                    r_capped;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    wr;
    t_cfg                    cfg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr      = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows[0] <= ROW0_RST;
            r_rows[1] <= ROW1_RST;
            r_rows[2] <= ROW2_RST;
            r_rows[3] <= ROW3_RST;
            r_subdiv  <= SUBDIV_RST;
            r_capped  <= 1'b1;
        end else if (wr) begin
            unique case (reg_idx)
                REG_ROW0:   r_rows[0] <= pwdata;
                REG_ROW1:   r_rows[1] <= pwdata;
                REG_ROW2:   r_rows[2] <= pwdata;
                REG_ROW3:   r_rows[3] <= pwdata;
                REG_SUBDIV: r_subdiv  <= pwdata[SUB_W-1:0];
                REG_CAPPED: r_capped  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_ROW0:   prdata = r_rows[0];
            REG_ROW1:   prdata = r_rows[1];
            REG_ROW2:   prdata = r_rows[2];
            REG_ROW3:   prdata = r_rows[3];
            REG_SUBDIV: prdata = PDATA_W'(r_subdiv);
            REG_CAPPED: prdata = PDATA_W'(r_capped);
            default:    prdata = '0;
        endcase
    end

    // effective settings
    always_comb begin
        cfg.rows   = r_rows;
        cfg.s_eff  = (r_subdiv > SUB_W'(SUBDIV_MAX)) ? SUB_W'(SUBDIV_MAX) : r_subdiv;
        cfg.capped = r_capped;
    end

    // front end and queue
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    t_job              f_job;
    t_job              q_head;

    cvg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (f_job)
    );

    cvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // vertex back end and divide
    logic   en;
    logic   b_vld;
    logic   b_last;
    t_sums  b_sums;

    cvg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_vld     (b_vld),
        .o_last    (b_last),
        .o_sums    (b_sums)
    );

    cvg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (b_vld),
        .i_last      (b_last),
        .i_sums      (b_sums),
        .i_out_stall (i_out_stall),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // checks
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full && !q_pop))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("item presented right after reset");

    a_wzero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.w_zero) |->
        (o_out_data.pos_x == POS_MAX || o_out_data.pos_x == POS_MIN ||
         o_out_data.pos_x == '0))
        else $error("zero w without saturated coordinate");

endmodule

`default_nettype wire
